FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// types and codes shared by the double-ended queue and its checker
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH = 16;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = $clog2(DEQ_DEPTH);
   localparam int CNT_W     = $clog2(DEQ_DEPTH + 1);

   // request codes
   localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
   localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
   localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
   localparam logic [2:0] REQ_POP_BACK   = 3'd3;
   localparam logic [2:0] REQ_SEARCH     = 3'd4;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // front/back value reported for an empty queue
   localparam logic signed [DATA_W-1:0] EMPTY_MARK = '1;

   typedef struct packed {
      logic [2:0]               req_type;
      logic signed [DATA_W-1:0] value;
   } deq_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     found;
      logic [CNT_W-1:0]         length;
      logic signed [DATA_W-1:0] first_value;
      logic signed [DATA_W-1:0] last_value;
   } deq_rsp_type;

endpackage

FILE: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// a request taken in idle passes through update, an optional search walk,
// the fetch of the front and back entries, and the response strobe
// no new request is taken until the response is given; a search walks
// the store one entry a cycle through read port a
// reset: synchronous, clears state, head and count; the store itself is not cleared
// the response strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  deq_pkg::deq_req_type req_payload,
   output logic                rsp_valid,
   output deq_pkg::deq_rsp_type rsp_payload
);
   import deq_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
   localparam logic [2:0] S_UPDATE = 3'd1;  // pointer update and store write
   localparam logic [2:0] S_SCAN   = 3'd2;  // search walk, one entry a cycle
   localparam logic [2:0] S_FETCH  = 3'd3;  // read front and back entries
   localparam logic [2:0] S_RESP   = 3'd4;  // response strobe

   // circular store, one write port and two registered read ports
   logic [DATA_W-1:0] mem [DEQ_DEPTH];

   logic [2:0]        state_ff, state_in;
   deq_req_type       req_ff;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [1:0]        status_ff, status_in;
   logic              found_ff, found_in;
   logic              cmp_valid_ff;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
   logic [CNT_W-1:0]  count_m1;
   logic              is_full, queue_empty, scan_last, accept;

   // index add modulo the store depth, both operands below the depth
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] pos,
                                                 input logic [IDX_W-1:0] step);
      logic [IDX_W:0] sum;
      sum = {1'b0, pos} + {1'b0, step};
      if (sum >= (IDX_W+1)'(DEQ_DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEQ_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign is_full     = (count_ff == CNT_W'(DEQ_DEPTH));
   assign queue_empty = (count_ff == '0);
   assign count_m1    = count_ff - 1'b1;
   // last scan read is issued at offset count-1
   assign scan_last = ({1'b0, scan_ff} == count_m1);

   // read port a walks the queue during a search, else reads the front
   assign rd_a_addr = (state_ff == S_SCAN) ? wrap_add(head_ff, scan_ff) : head_ff;
   // read port b always points at the back entry
   assign rd_b_addr = wrap_add(head_ff, count_m1[IDX_W-1:0]);

   // sequencer and the update of head and count
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      // shared compare: registered read data against the search value
      found_in  = found_ff | (cmp_valid_ff && (rd_a_ff == req_ff.value));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_UPDATE;
               status_in = ST_DONE;
               found_in  = 1'b0;
            end
         end
         S_UPDATE: begin
            state_in = S_FETCH;
            case (req_ff.req_type)
               REQ_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     // head steps back one place, new entry goes there
                     head_in  = wrap_add(head_ff, IDX_W'(DEQ_DEPTH - 1));
                     wr_en    = 1'b1;
                     wr_addr  = wrap_add(head_ff, IDX_W'(DEQ_DEPTH - 1));
                     count_in = count_ff + 1'b1;
                  end
               end
               REQ_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     // count is below the depth here, so it fits an index
                     wr_en    = 1'b1;
                     wr_addr  = wrap_add(head_ff, count_ff[IDX_W-1:0]);
                     count_in = count_ff + 1'b1;
                  end
               end
               REQ_POP_FRONT: begin
                  if (queue_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     head_in  = wrap_add(head_ff, IDX_W'(1));
                     count_in = count_m1;
                  end
               end
               REQ_POP_BACK: begin
                  if (queue_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     count_in = count_m1;
                  end
               end
               REQ_SEARCH: begin
                  if (queue_empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  // unknown request codes leave the queue untouched
               end
            endcase
         end
         S_SCAN: begin
            // compare of the final entry lands during the fetch cycle
            if (scan_last) begin
               state_in = S_FETCH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_FETCH: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         // a read issued in a scan cycle is compared in the cycle after
         cmp_valid_ff <= (state_ff == S_SCAN);
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      scan_ff   <= scan_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // store: one write, two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ff.value;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   // response, front and back read back during the fetch cycle
   assign rsp_valid               = (state_ff == S_RESP);
   assign rsp_payload.status      = status_ff;
   assign rsp_payload.found       = found_ff;
   assign rsp_payload.length      = count_ff;
   assign rsp_payload.first_value = queue_empty ? EMPTY_MARK : rd_a_ff;
   assign rsp_payload.last_value  = queue_empty ? EMPTY_MARK : rd_b_ff;

endmodule

FILE: sv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks on the double-ended queue, bound to double_ended_queue
// ----------------------------------------------------------------------------
module deq_port_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input deq_pkg::deq_rsp_type rsp_payload
);
   import deq_pkg::*;

   // an accepted request makes the block busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after an accepted request");

   // a response strobe is never followed directly by another
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // an empty queue reports the empty mark at both ends
   a_empty_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.length == '0) |->
         (rsp_payload.first_value == EMPTY_MARK &&
          rsp_payload.last_value == EMPTY_MARK))
      else $error("empty queue without empty marks");

   // a hit only comes with a done status
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.found) |-> (rsp_payload.status == ST_DONE))
      else $error("found flag with a failing status");

   // length never exceeds the store depth
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.length <= CNT_W'(DEQ_DEPTH)))
      else $error("length beyond depth");

endmodule

bind double_ended_queue deq_port_checker u_deq_port_checker (.*);
